@@ src/psc_pkg.sv @@
`default_nettype none

package psc_pkg;

	// opcodes of an incoming item
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_REPLY  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// completion status codes
	localparam logic [2:0] ST_SUCCESS    = 3'd0;
	localparam logic [2:0] ST_BUSY       = 3'd1;
	localparam logic [2:0] ST_TIMEOUT    = 3'd2;
	localparam logic [2:0] ST_REFUSED    = 3'd3;
	localparam logic [2:0] ST_START_FAIL = 3'd4;

	// result kinds and ports
	localparam logic KIND_WRITE    = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;
	localparam logic PORT_DATA     = 1'b0;
	localparam logic PORT_CTRL     = 1'b1;

	localparam logic [7:0] MOUSE_PREFIX = 8'hD4;
	localparam logic [7:0] REPLY_RESEND = 8'hFE;
	localparam logic [7:0] REPLY_REFUSE = 8'hFC;

	localparam logic [7:0] RESEND_LIMIT_RESET = 8'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic [4:0] byte_count;
		logic       to_mouse;
		logic       write_ok;
	} cmd_item_t;

	typedef struct packed {
		logic       kind;
		logic       port_select;
		logic [7:0] write_value;
		logic [2:0] status;
		logic       last;
	} res_item_t;

endpackage

`default_nettype wire

@@ src/ps2_command_packet_sender.sv @@
// PS/2 command packet sender for an 8042-style controller.
// Command channel (cmd_valid/cmd_stall/cmd): load items write one byte of the
// packet buffer, a start item begins a packet, reply items carry the device's
// answer byte. Result channel (res_valid/res_stall/res): port writes (a 0xD4
// control write ahead of each mouse byte, then the data byte) and completions
// with a status; last marks the final result of an item.
// Configuration: cfg_we/cfg_data write resend_limit (3 after reset).
// Accepted items with results are registered in stage 1, their results in the
// result register. An item with a mouse prefix holds the next back while the
// prefix is sent, as the single result register drains one result per cycle
// unless the receiver stalls. The packet buffer is a synchronous RAM read once
// per item that sends a byte; its registered read data travels with the item.
// Reset clears the control state and sets resend_limit to 3; buffer bytes stay
// unknown until loaded. When the receiver stalls, the result register holds,
// the pending item waits behind it, and cmd_stall rises once that stage is full.
`default_nettype none

module ps2_command_packet_sender #(
	parameter int MAX_PACKET_BYTES = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cmd_valid,
	output logic                   cmd_stall,
	input  wire psc_pkg::cmd_item_t cmd,
	output logic                   res_valid,
	input  wire                    res_stall,
	output psc_pkg::res_item_t     res,
	input  wire                    cfg_we,
	input  wire  [7:0]             cfg_data
);

	localparam int AW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
	localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CW = (PW > 5) ? PW : 5;

	// control state
	logic [7:0]    limit_q;
	logic          sending_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] len_q;
	logic          mouse_q;
	logic [8:0]    tally_q;

	logic [7:0] buf_mem [MAX_PACKET_BYTES];

	// stage 1: decided results of the accepted item
	logic       valid_s1;
	logic       pref_s1;
	logic       byte_s1;
	logic [2:0] status_s1;
	logic [7:0] rd_data_s1;

	logic      res_valid_q;
	psc_pkg::res_item_t res_q;

	logic accept;
	logic out_free;
	logic emit;
	logic emit_last;
	psc_pkg::res_item_t emit_item;

	// next-state and decision values
	logic          sending_d;
	logic [PW-1:0] pos_d;
	logic [PW-1:0] len_d;
	logic          mouse_d;
	logic [8:0]    tally_d;
	logic          any_d;
	logic          pref_d;
	logic          byte_d;
	logic [2:0]    status_d;
	logic [PW-1:0] rd_pos;

	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] cnt_cl;
	logic [CW-1:0] idx_ext;
	logic [8:0]    tally_inc;
	logic          is_resend;
	logic          is_refuse;
	logic [PW-1:0] pos_back;
	logic          load_we;

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = valid_s1 && !(out_free && !pref_s1);
	assign accept    = cmd_valid && !cmd_stall;

	assign cnt_ext   = CW'(cmd.byte_count);
	assign idx_ext   = CW'(cmd.byte_index);
	assign tally_inc = tally_q + 9'd1;
	assign is_resend = cmd.byte_value == psc_pkg::REPLY_RESEND;
	assign is_refuse = cmd.byte_value == psc_pkg::REPLY_REFUSE;
	assign pos_back  = (is_resend && pos_q != '0) ? pos_q - PW'(1) : pos_q;
	assign load_we   = accept && cmd.opcode == psc_pkg::OP_LOAD
		&& idx_ext < CW'(MAX_PACKET_BYTES);

	always_comb begin
		if (cnt_ext == '0) begin
			cnt_cl = CW'(1);
		end else if (cnt_ext > CW'(MAX_PACKET_BYTES)) begin
			cnt_cl = CW'(MAX_PACKET_BYTES);
		end else begin
			cnt_cl = cnt_ext;
		end
	end

	always_comb begin
		sending_d = sending_q;
		pos_d     = pos_q;
		len_d     = len_q;
		mouse_d   = mouse_q;
		tally_d   = tally_q;
		any_d     = 1'b0;
		pref_d    = 1'b0;
		byte_d    = 1'b0;
		status_d  = psc_pkg::ST_SUCCESS;
		rd_pos    = pos_q;
		if (cmd.opcode == psc_pkg::OP_START) begin
			any_d = 1'b1;
			if (sending_q) begin
				status_d = psc_pkg::ST_BUSY;
			end else begin
				mouse_d = cmd.to_mouse;
				len_d   = cnt_cl[PW-1:0];
				tally_d = '0;
				rd_pos  = '0;
				if (!cmd.write_ok) begin
					pos_d    = '0;
					status_d = psc_pkg::ST_START_FAIL;
				end else begin
					sending_d = 1'b1;
					pos_d     = PW'(1);
					pref_d    = cmd.to_mouse;
					byte_d    = 1'b1;
				end
			end
		end else if (cmd.opcode == psc_pkg::OP_REPLY && sending_q) begin
			any_d = 1'b1;
			priority if (is_resend && tally_inc > {1'b0, limit_q}) begin
				tally_d   = '0;
				sending_d = 1'b0;
				status_d  = psc_pkg::ST_TIMEOUT;
			end else if (is_refuse) begin
				tally_d   = '0;
				sending_d = 1'b0;
				status_d  = psc_pkg::ST_REFUSED;
			end else begin
				tally_d = is_resend ? tally_inc : 9'd0;
				pos_d   = pos_back;
				rd_pos  = pos_back;
				if (pos_back >= len_q) begin
					sending_d = 1'b0;
					status_d  = psc_pkg::ST_SUCCESS;
				end else if (!cmd.write_ok) begin
					sending_d = 1'b0;
					status_d  = psc_pkg::ST_TIMEOUT;
				end else begin
					pos_d  = pos_back + PW'(1);
					pref_d = mouse_q;
					byte_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= psc_pkg::RESEND_LIMIT_RESET;
			sending_q <= 1'b0;
			pos_q     <= '0;
			len_q     <= '0;
			mouse_q   <= 1'b0;
			tally_q   <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				sending_q <= sending_d;
				pos_q     <= pos_d;
				len_q     <= len_d;
				mouse_q   <= mouse_d;
				tally_q   <= tally_d;
			end
		end
	end

	// packet buffer: one write port for loads, one registered read per sent byte
	always_ff @(posedge clk) begin
		if (load_we) begin
			buf_mem[idx_ext[AW-1:0]] <= cmd.byte_value;
		end
		if (accept && byte_d) begin
			rd_data_s1 <= buf_mem[rd_pos[AW-1:0]];
		end
	end

	assign emit      = valid_s1 && out_free;
	assign emit_last = emit && !pref_s1;

	always_comb begin
		emit_item = '0;
		if (pref_s1) begin
			emit_item.kind        = psc_pkg::KIND_WRITE;
			emit_item.port_select = psc_pkg::PORT_CTRL;
			emit_item.write_value = psc_pkg::MOUSE_PREFIX;
		end else if (byte_s1) begin
			emit_item.kind        = psc_pkg::KIND_WRITE;
			emit_item.port_select = psc_pkg::PORT_DATA;
			emit_item.write_value = rd_data_s1;
			emit_item.last        = 1'b1;
		end else begin
			emit_item.kind   = psc_pkg::KIND_COMPLETE;
			emit_item.status = status_s1;
			emit_item.last   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pref_s1     <= 1'b0;
			byte_s1     <= 1'b0;
			status_s1   <= psc_pkg::ST_SUCCESS;
			res_valid_q <= 1'b0;
		end else begin
			if (accept && any_d) begin
				valid_s1  <= 1'b1;
				pref_s1   <= pref_d;
				byte_s1   <= byte_d;
				status_s1 <= status_d;
			end else if (emit_last) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				pref_s1 <= 1'b0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire
